>>> hw/rtl/wvr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvr_pkg
// Shared types and constants for the radiometer path coefficient table.
// ----------------------------------------------------------------------------
package wvr_pkg;

   localparam int unsigned MaxEntries = 64;
   localparam int unsigned IdxW       = $clog2(MaxEntries);
   localparam int unsigned CntW       = $clog2(MaxEntries + 1);

   localparam logic [31:0] NoiseReset0 = 32'd6553600;
   localparam logic [31:0] NoiseReset1 = 32'd10240000;
   localparam logic [31:0] NoiseReset2 = 32'd10240000;
   localparam logic [31:0] NoiseReset3 = 32'd8090864;

   localparam logic [1:0] CsrNoise0 = 2'd0;
   localparam logic [1:0] CsrNoise1 = 2'd1;
   localparam logic [1:0] CsrNoise2 = 2'd2;
   localparam logic [1:0] CsrNoise3 = 2'd3;

   localparam logic ReqAdd = 1'b0;
   localparam logic ReqCal = 1'b1;

   localparam logic [1:0] StAdded   = 2'd0;
   localparam logic [1:0] StCal     = 2'd1;
   localparam logic [1:0] StNoMatch = 2'd2;
   localparam logic [1:0] StFull    = 2'd3;

   localparam logic [31:0] MinusOne = 32'hFFFF0000;

   // 128-bit division: one quotient bit per cycle, only the low 64 matter
   localparam int unsigned DivSteps = 128;
   localparam int unsigned DivCntW  = $clog2(DivSteps);

   // one bit-serial divider cell per channel
   localparam int unsigned NumCells = 4;

   typedef struct packed {
      logic [31:0]       t0;
      logic [31:0]       t1;
      logic signed [15:0] src;
      logic [7:0]        ant;
      logic [3:0][31:0]  coef;
   } entry_type;

   // control from the sequencer into the divider row
   typedef struct packed {
      logic load;
      logic step;
   } div_ctl_type;

endpackage
`default_nettype wire

>>> hw/rtl/wvr_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvr_div_cell
// Restoring divider cell: one quotient bit per step of p*2^32 / S, then sign
// and saturation. The shared divisor is handed on to the next cell.
// ----------------------------------------------------------------------------
module wvr_div_cell (
   input  wire                       clock,
   input  wire wvr_pkg::div_ctl_type ctl,
   input  wire [63:0]                p,
   input  wire                       neg,
   input  wire [127:0]               div_i,
   output logic [127:0]              div_o,
   output logic [31:0]               coef
);
   import wvr_pkg::*;

   logic [127:0] num_ff, num_in;
   logic [127:0] rem_ff, rem_in;
   logic [63:0]  q_ff, q_in;
   logic         neg_ff, neg_in;
   logic         zero_ff, zero_in;
   logic [127:0] div_ff, div_in;
   logic [128:0] shifted;
   logic [128:0] diff;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      div_in  = div_ff;
      shifted = {rem_ff, num_ff[127]};
      diff    = shifted - {1'b0, div_ff};
      if (ctl.load) begin
         num_in  = {p, 64'd0} >> 32;
         rem_in  = '0;
         q_in    = '0;
         neg_in  = neg;
         zero_in = (p == 64'd0) || (div_i == 128'd0);
         div_in  = div_i;
      end else if (ctl.step) begin
         num_in = {num_ff[126:0], 1'b0};
         if (!diff[128]) begin
            rem_in = diff[127:0];
            q_in   = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted[127:0];
            q_in   = {q_ff[62:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      div_ff  <= div_in;
   end

   // every cell loads the same divisor in the load cycle
   assign div_o = div_i;

   always_comb begin
      if (zero_ff) begin
         coef = '0;
      end else if (neg_ff) begin
         coef = (q_ff > 64'h80000000) ? 32'h80000000 : (32'd0 - q_ff[31:0]);
      end else begin
         coef = (q_ff > 64'h7FFFFFFF) ? 32'h7FFFFFFF : q_ff[31:0];
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/wvr_path_coefficient_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wvr_path_coefficient_table
// Radiometer coefficient table: stores noise-weighted entries and turns
// four brightness temperatures into an excess path.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with the req_ fields while busy is low. req_type add stores
//   an entry and computes its four coefficients in a row of four divider
//   cells that share the 128-bit weight sum; req_type calibrate scans the
//   table in insertion order, one entry read per cycle from the memory.
//   Each transaction gives exactly one result, held on rsp_ for one cycle
//   with rsp_valid high; the receiver cannot stall it.
//   Steps: add runs four multiply/square pairs, the divider load, 128
//   divide steps and the table write; a full table goes straight to the
//   response. Calibrate makes up to two scan passes through the memory
//   read port, the second without the time test, and stops at the first
//   match; the four products and the saturating sum follow a match. busy
//   stays high through the response cycle; the next transaction is taken
//   after it. Reset empties the table (count to zero) and loads the noise
//   registers with their defaults; csr_ writes apply at the next edge. The
//   user must make them only while no transaction is in flight; the block
//   itself does not enforce it.
// ----------------------------------------------------------------------------
module wvr_path_coefficient_table (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  wire               req_type,
   input  wire [31:0]        req_time_begin,
   input  wire [31:0]        req_time_end,
   input  wire signed [15:0] req_source_id,
   input  wire [7:0]         req_antenna,
   input  wire signed [31:0] req_value_0,
   input  wire signed [31:0] req_value_1,
   input  wire signed [31:0] req_value_2,
   input  wire signed [31:0] req_value_3,
   input  wire               csr_we,
   input  wire [1:0]         csr_index,
   input  wire [31:0]        csr_wdata,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic signed [31:0] rsp_excess_path
);
   import wvr_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_MUL   = 11'b00000000010,
      S_SQ    = 11'b00000000100,
      S_SUM   = 11'b00000001000,
      S_DIV   = 11'b00000010000,
      S_WR    = 11'b00000100000,
      S_SCAN  = 11'b00001000000,
      S_DOT   = 11'b00010000000,
      S_ACC   = 11'b00100000000,
      S_OUT   = 11'b01000000000,
      S_RD    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic [3:0][31:0] noise_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         noise_ff <= {NoiseReset3, NoiseReset2, NoiseReset1, NoiseReset0};
      end else if (csr_we) begin
         case (csr_index)
            CsrNoise0: noise_ff[0] <= csr_wdata;
            CsrNoise1: noise_ff[1] <= csr_wdata;
            CsrNoise2: noise_ff[2] <= csr_wdata;
            CsrNoise3: noise_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // captured request
   logic [31:0] t0_ff, t1_ff;
   logic signed [15:0] src_ff;
   logic [7:0]  ant_ff;
   logic [3:0][31:0] val_ff;
   logic [CntW-1:0] count_ff;

   // add datapath: channels in turn, each through a multiply state and a square state
   logic [1:0]  ch_ff;
   logic [3:0][31:0] mag_ff;
   logic [3:0]  neg_ff;
   logic [3:0][63:0] p_ff;
   logic [127:0] sum_ff;
   logic [DivCntW:0] dcnt_ff;

   // memory
   entry_type mem [MaxEntries];
   entry_type rd_ff;
   logic [IdxW-1:0] rd_addr;
   logic [CntW-1:0] k_ff;
   logic        pass_ff;
   logic        rd_ok_ff;
   entry_type   hent_ff;

   // dot product
   logic signed [63:0] prod_ff;
   logic signed [65:0] acc_ff;
   logic [1:0]  status_ff;
   logic [31:0] res_ff;
   logic        out_ff;

   logic [3:0][31:0] coef_w;
   logic [4:0][127:0] dchain;
   div_ctl_type dctl;
   logic [31:0] cur_mag;
   logic [63:0] cur_mul;

   assign dchain[0] = sum_ff;
   assign dctl.load = (state_ff == S_SUM);
   assign dctl.step = (state_ff == S_DIV);

   for (genvar g = 0; g < NumCells; g++) begin : g_cell
      wvr_div_cell u_cell (
         .clock (clock),
         .ctl   (dctl),
         .p     (p_ff[g]),
         .neg   (neg_ff[g]),
         .div_i (dchain[g]),
         .div_o (dchain[g+1]),
         .coef  (coef_w[g])
      );
   end

   assign cur_mag = val_ff[ch_ff][31] ? (32'd0 - val_ff[ch_ff]) : val_ff[ch_ff];
   assign cur_mul = (state_ff == S_MUL) ? (64'(cur_mag) * 64'(noise_ff[ch_ff]))
                                       : 64'd0;

   logic match_w, time_w;
   assign time_w  = (t0_ff >= rd_ff.t0 && t0_ff <= rd_ff.t1) || (t0_ff > rd_ff.t1);
   assign match_w = (rd_ff.ant == ant_ff) && (src_ff < 0 || rd_ff.src == src_ff)
                    && (pass_ff || time_w);
   assign rd_addr = k_ff[IdxW-1:0];

   always_ff @(posedge clock) begin
      if (state_ff == S_WR)
         mem[count_ff[IdxW-1:0]] <= '{t0: t0_ff, t1: t1_ff, src: src_ff, ant: ant_ff,
                                     coef: coef_w};
      rd_ff <= mem[rd_addr];
   end

   logic signed [31:0] dv;
   logic signed [31:0] dc;
   assign dv = val_ff[ch_ff];
   assign dc = hent_ff.coef[ch_ff];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (start && !busy) state_in = req_type == ReqAdd ?
                   ((count_ff >= CntW'(MaxEntries)) ? S_OUT : S_MUL) : S_RD;
         S_MUL:  state_in = S_SQ;
         S_SQ:   state_in = (ch_ff == 2'd3) ? S_SUM : S_MUL;
         S_SUM:  state_in = S_DIV;
         S_DIV:  if (dcnt_ff == (DivCntW+1)'(DivSteps - 1)) state_in = S_WR;
         S_WR:   state_in = S_OUT;
         S_RD:   state_in = S_SCAN;
         S_SCAN: begin
            if (rd_ok_ff && match_w) state_in = S_DOT;
            else if (k_ff >= count_ff && !rd_ok_ff && pass_ff) state_in = S_OUT;
         end
         S_DOT:  state_in = S_ACC;
         S_ACC:  state_in = (ch_ff == 2'd3) ? S_OUT : S_DOT;
         S_OUT:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         out_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff   <= (state_ff == S_OUT);
         if (state_ff == S_WR) count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            t0_ff <= req_time_begin; t1_ff <= req_time_end;
            src_ff <= req_source_id; ant_ff <= req_antenna;
            val_ff <= {req_value_3, req_value_2, req_value_1, req_value_0};
            ch_ff <= '0; sum_ff <= '0; dcnt_ff <= '0;
            k_ff <= '0; pass_ff <= 1'b0; rd_ok_ff <= 1'b0; acc_ff <= '0;
            status_ff <= StFull; res_ff <= '0;
         end
         S_MUL: begin
            mag_ff[ch_ff] <= cur_mag;
            neg_ff[ch_ff] <= val_ff[ch_ff][31];
            p_ff[ch_ff]   <= cur_mul;
         end
         S_SQ: begin
            // p < 2^64, |d| < 2^32: split product keeps each multiplier at 32 bits
            sum_ff <= sum_ff + 128'(p_ff[ch_ff][31:0] * 64'(mag_ff[ch_ff]))
                    + (128'(p_ff[ch_ff][63:32] * 64'(mag_ff[ch_ff])) << 32);
            ch_ff <= ch_ff + 1'b1;
         end
         S_DIV: dcnt_ff <= dcnt_ff + 1'b1;
         S_WR: begin status_ff <= StAdded; res_ff <= '0; end
         S_RD: begin
            k_ff <= k_ff + 1'b1;
            rd_ok_ff <= (k_ff < count_ff);
         end
         S_SCAN: begin
            ch_ff <= '0;
            if (rd_ok_ff && match_w) begin
               hent_ff <= rd_ff;
            end else if (k_ff >= count_ff && !rd_ok_ff) begin
               pass_ff <= 1'b1;
               k_ff <= '0;
               status_ff <= StNoMatch; res_ff <= MinusOne;
            end else begin
               rd_ok_ff <= (k_ff < count_ff);
               k_ff <= (k_ff < count_ff) ? k_ff + 1'b1 : k_ff;
            end
         end
         S_DOT: prod_ff <= dv * dc;
         S_ACC: begin
            acc_ff <= acc_ff + 66'(prod_ff);
            ch_ff <= ch_ff + 1'b1;
            if (ch_ff == 2'd3) begin
               status_ff <= StCal;
               if ((acc_ff + 66'(prod_ff)) >= 66'sh0 &&
                   (acc_ff + 66'(prod_ff)) < 66'sh8000_0000_0000)
                  res_ff <= 32'((acc_ff + 66'(prod_ff)) >>> 16);
               else if ((acc_ff + 66'(prod_ff)) < 66'sh0 &&
                        (acc_ff + 66'(prod_ff)) >= -66'sh8000_0000_0000)
                  res_ff <= 32'((acc_ff + 66'(prod_ff)) >>> 16);
               else if ((acc_ff + 66'(prod_ff)) < 66'sh0)
                  res_ff <= 32'h80000000;
               else
                  res_ff <= 32'h7FFFFFFF;
            end
         end
         default: ;
      endcase
   end

   assign busy            = (state_ff != S_IDLE) || out_ff;
   assign rsp_valid       = out_ff;
   assign rsp_status      = status_ff;
   assign rsp_excess_path = res_ff;

`ifndef SYNTH
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MaxEntries)) else $error("entry count overflow");
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double response");
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == StAdded |-> count_ff != '0)
      else $error("add without entry");
`endif

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the radiometer path coefficient table: a directed
// table of add and calibrate requests, then random traffic over several noise
// register settings, each response checked against a predictor or preset values.
// ----------------------------------------------------------------------------
module tb;
   import wvr_pkg::*;

   localparam int unsigned CycleLimit = 600000;

   typedef struct {
      logic              kind;
      logic [31:0]       t0;
      logic [31:0]       t1;
      logic signed [15:0] src;
      logic [7:0]        ant;
      logic [3:0][31:0]  val;
      bit                typed;
      logic [1:0]        st;
      logic [31:0]       path;
   } req_row;

   typedef struct {
      logic [1:0]  st;
      logic [31:0] path;
   } rsp_item;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_type = 1'b0;
   logic [31:0]       req_time_begin = '0;
   logic [31:0]       req_time_end = '0;
   logic signed [15:0] req_source_id = '0;
   logic [7:0]        req_antenna = '0;
   logic signed [31:0] req_value_0 = '0;
   logic signed [31:0] req_value_1 = '0;
   logic signed [31:0] req_value_2 = '0;
   logic signed [31:0] req_value_3 = '0;
   logic              csr_we = 1'b0;
   logic [1:0]        csr_index = '0;
   logic [31:0]       csr_wdata = '0;
   logic              rsp_valid;
   logic [1:0]        rsp_status;
   logic signed [31:0] rsp_excess_path;

   wvr_path_coefficient_table uut (.*);

   always #6 clock = ~clock;

   // predictor state
   logic [31:0] noise_sq [4];
   entry_type   table_mem [MaxEntries];
   int unsigned table_count;

   rsp_item     pending_q[$];
   int unsigned mismatches = 0;
   int unsigned cycles = 0;
   req_row      rows[$];
   int          item_no = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [3:0][31:0] weigh(input logic [3:0][31:0] d);
      logic [127:0] mag[4], prod[4], sum, q;
      logic signed [63:0] dv;
      logic [3:0][31:0] c;
      sum = '0;
      for (int i = 0; i < 4; i++) begin
         dv = $signed(d[i]);
         mag[i] = (dv < 0) ? 128'(-dv) : 128'(dv);
         prod[i] = mag[i] * noise_sq[i];
         sum += prod[i] * mag[i];
      end
      for (int i = 0; i < 4; i++) begin
         if (sum == 0 || prod[i] == 0) begin
            c[i] = '0;
         end else begin
            q = (prod[i] << 32) / sum;
            if (d[i][31]) begin
               if (q > 128'h8000_0000) q = 128'h8000_0000;
               c[i] = 32'(0) - q[31:0];
            end else begin
               if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
               c[i] = q[31:0];
            end
         end
      end
      return c;
   endfunction

   function automatic rsp_item serve(input req_row r);
      rsp_item res;
      int hit;
      logic signed [127:0] acc;
      logic signed [63:0] a, b;
      hit = -1;
      if (r.kind == ReqAdd) begin
         res.path = '0;
         if (table_count >= MaxEntries) begin
            res.st = StFull;
         end else begin
            table_mem[table_count].t0 = r.t0;
            table_mem[table_count].t1 = r.t1;
            table_mem[table_count].src = r.src;
            table_mem[table_count].ant = r.ant;
            table_mem[table_count].coef = weigh(r.val);
            table_count++;
            res.st = StAdded;
         end
         return res;
      end
      // time inside or after the range wins; otherwise first antenna/source hit
      for (int k = 0; k < table_count && hit < 0; k++)
         if (table_mem[k].ant == r.ant && (r.src < 0 || table_mem[k].src == r.src)
             && r.t0 >= table_mem[k].t0 || table_mem[k].ant == r.ant
             && (r.src < 0 || table_mem[k].src == r.src) && r.t0 > table_mem[k].t1)
            hit = k;
      for (int k = 0; k < table_count && hit < 0; k++)
         if (table_mem[k].ant == r.ant && (r.src < 0 || table_mem[k].src == r.src))
            hit = k;
      if (hit < 0) begin
         res.st = StNoMatch;
         res.path = MinusOne;
         return res;
      end
      acc = '0;
      for (int i = 0; i < 4; i++) begin
         a = $signed(r.val[i]);
         b = $signed(table_mem[hit].coef[i]);
         acc += a * b;
      end
      res.st = StCal;
      if (acc >= -(128'sd1 <<< 47) && acc < (128'sd1 <<< 47))
         res.path = acc[47:16];
      else if (acc < 0)
         res.path = 32'h8000_0000;
      else
         res.path = 32'h7FFF_FFFF;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_item want;
      if (!reset && rsp_valid) begin
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response status=%0d path=%h", rsp_status,
                        rsp_excess_path);
         end else begin
            want = pending_q.pop_front();
            if (rsp_status !== want.st || rsp_excess_path !== want.path) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp status=%0d path=%h got status=%0d path=%h",
                           want.st, want.path, rsp_status, rsp_excess_path);
            end
         end
      end
   end

   task automatic row(input logic kind, input logic [31:0] t0, input logic [31:0] t1,
                      input logic signed [15:0] src, input logic [7:0] ant,
                      input logic [3:0][31:0] val, input bit typed = 0,
                      input logic [1:0] st = StAdded, input logic [31:0] path = '0);
      req_row r;
      r.kind = kind; r.t0 = t0; r.t1 = t1; r.src = src; r.ant = ant; r.val = val;
      r.typed = typed; r.st = st; r.path = path;
      rows.push_back(r);
   endtask

   task automatic send(input req_row r, input bit may_idle);
      rsp_item want;
      int gap;
      gap = (may_idle && $urandom_range(0, 99) < 21) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_type <= r.kind;
      req_time_begin <= r.t0;
      req_time_end <= r.t1;
      req_source_id <= r.src;
      req_antenna <= r.ant;
      req_value_0 <= r.val[0];
      req_value_1 <= r.val[1];
      req_value_2 <= r.val[2];
      req_value_3 <= r.val[3];
      @(posedge clock);
      while (busy) @(posedge clock);
      want = serve(r);
      if (r.typed) begin
         want.st = r.st;
         want.path = r.path;
      end
      pending_q.push_back(want);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      noise_sq[idx] = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic req_row random_req();
      req_row r;
      int sel;
      r.typed = 0; r.st = StAdded; r.path = '0;
      r.kind = ($urandom_range(0, 99) < 12) ? ReqAdd : ReqCal;
      if ($urandom_range(0, 9) == 0) begin
         r.t0 = $urandom();
         r.t1 = $urandom();
      end else begin
         r.t0 = $urandom_range(0, 1000) << 16;
         r.t1 = r.t0 + ($urandom_range(0, 200) << 16);
      end
      sel = $urandom_range(0, 9);
      if (sel == 0) r.src = 16'($urandom());
      else if (sel < 3 && r.kind == ReqCal) r.src = -16'sd1;
      else r.src = 16'($urandom_range(0, 3));
      r.ant = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3));
      for (int i = 0; i < 4; i++) begin
         sel = $urandom_range(0, 5);
         if (sel == 0) r.val[i] = $urandom();
         else if (sel == 1) r.val[i] = '0;
         else r.val[i] = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      end
      return r;
   endfunction

   initial begin
      noise_sq[0] = NoiseReset0;
      noise_sq[1] = NoiseReset1;
      noise_sq[2] = NoiseReset2;
      noise_sq[3] = NoiseReset3;
      table_count = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, ranges, fallback, zero sum, saturation
      row(ReqCal, 32'd150 << 16, 0, 16'sd5, 8'd1, '0, 1, StNoMatch, MinusOne);
      row(ReqAdd, 32'd100 << 16, 32'd200 << 16, 16'sd5, 8'd1,
          {32'd0, 32'd0, 32'd0, 32'h0001_0000}, 1, StAdded, '0);
      row(ReqCal, 32'd150 << 16, 0, 16'sd5, 8'd1, {32'd0, 32'd0, 32'd0, 32'h0002_0000});
      row(ReqAdd, 32'd0, 32'd10, 16'sd7, 8'd2, '0, 1, StAdded, '0);
      row(ReqCal, 32'd5, 0, 16'sd7, 8'd2, {4{32'h7FFF_FFFF}}, 1, StCal, '0);
      row(ReqAdd, 32'd0, 32'hFFFF_FFFF, 16'sd32767, 8'd255,
          {32'hFFFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000});
      row(ReqCal, 32'd0, 32'hFFFF_FFFF, -16'sd1, 8'd255,
          {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
      row(ReqCal, 32'hFFFF_FFFF, 0, 16'sd32767, 8'd255, {4{32'hFFFF_FFFF}});
      row(ReqCal, 32'd50 << 16, 0, -16'sd1, 8'd1, {4{32'h0001_0000}});
      row(ReqCal, 32'd150 << 16, 0, 16'sd6, 8'd1, '0, 1, StNoMatch, MinusOne);
      row(ReqAdd, 32'd300 << 16, 32'd400 << 16, 16'sd5, 8'd1,
          {32'h0000_8000, 32'hFFFF_0000, 32'h0003_0000, 32'h0001_0000});
      row(ReqCal, 32'd350 << 16, 0, 16'sd5, 8'd1, {4{32'h0010_0000}});
      row(ReqAdd, 32'd0, 32'd0, -16'sd1, 8'd3, {32'd0, 32'd0, 32'd0, 32'd1});
      row(ReqCal, 32'd9, 0, -16'sd1, 8'd3, {32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF});
      row(ReqCal, 32'd9, 0, 16'sd2, 8'd3, '0, 1, StNoMatch, MinusOne);
      row(ReqAdd, 32'd0, 32'd0, 16'sd9, 8'd4, {32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF});
      row(ReqCal, 32'd0, 0, 16'sd9, 8'd4, {32'd0, 32'd0, 32'd0, 32'h8000_0000});
      row(ReqCal, 32'd0, 0, 16'sd9, 8'd4, {32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF});
      foreach (rows[i]) send(rows[i], 1);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               csr_write(CsrNoise0, 32'd0);
               csr_write(CsrNoise1, 32'hFFFF_FFFF);
               csr_write(CsrNoise2, 32'd1);
               csr_write(CsrNoise3, 32'h8000_0000);
            end
            1: begin
               csr_write(CsrNoise0, $urandom());
               csr_write(CsrNoise1, $urandom());
               csr_write(CsrNoise2, $urandom());
               csr_write(CsrNoise3, $urandom());
            end
            2: begin
               csr_write(CsrNoise0, 32'hFFFF_FFFF);
               csr_write(CsrNoise1, 32'd0);
               csr_write(CsrNoise2, 32'hFFFF_FFFF);
               csr_write(CsrNoise3, 32'd1);
            end
            default: begin
               csr_write(CsrNoise0, NoiseReset0);
               csr_write(CsrNoise1, NoiseReset1);
               csr_write(CsrNoise2, NoiseReset2);
               csr_write(CsrNoise3, NoiseReset3);
            end
         endcase
         for (int n = 0; n < 200; n++) begin
            send(random_req(), !(item_no >= 250 && item_no < 400));
            item_no++;
         end
         drain();
      end

      if (mismatches == 0 && pending_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
